// ===== sv/scancode_set1_to_ascii_defines.svh =====
// Assertion macros for the scancode set 1 to ASCII translator.
// Used by the RTL modules that carry checks; needs clk and arst_n in scope.
`ifndef SCANCODE_SET1_TO_ASCII_DEFINES_SVH
`define SCANCODE_SET1_TO_ASCII_DEFINES_SVH
`ifndef ASSERT_OFF
`define SC1A_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sc1a assertion failed");
`define SC1A_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("sc1a forbidden condition seen");
`else
`define SC1A_ASSERT(label, prop)
`define SC1A_NEVER(label, expr)
`endif
`endif

// ===== sv/sc1a_pkg.sv =====
// Shared constants, result type and character tables for the translator.
// No dependencies.
`default_nettype none
package sc1a_pkg;

	localparam logic [7:0] SC_EXT       = 8'hE0;
	localparam logic [7:0] SC_PAUSE     = 8'hE1;
	localparam logic [7:0] SC_CTRL      = 8'h1D;
	localparam logic [7:0] SC_LSHIFT    = 8'h2A;
	localparam logic [7:0] SC_RSHIFT    = 8'h36;
	localparam logic [7:0] SC_ALT       = 8'h38;
	localparam logic [7:0] SC_ROM_SIZE  = 8'h3A;
	localparam logic [7:0] SC_BREAK_BIT = 8'h80;

	localparam logic [6:0] KEY_ESC   = 7'h1B;
	localparam logic [6:0] KEY_BACK  = 7'h08;
	localparam logic [6:0] KEY_TAB   = 7'h09;
	localparam logic [6:0] KEY_ENTER = 7'h0A;

	typedef struct packed {
		logic       hit;
		logic [6:0] ch;
		logic       ctrl;
		logic       alt;
		logic       shift;
	} sc1a_res_t;

	function automatic logic [6:0] char_rom(input logic [5:0] idx);
		logic [6:0] c;
		unique case (idx)
			6'h01: c = KEY_ESC;
			6'h02: c = 7'h31;
			6'h03: c = 7'h32;
			6'h04: c = 7'h33;
			6'h05: c = 7'h34;
			6'h06: c = 7'h35;
			6'h07: c = 7'h36;
			6'h08: c = 7'h37;
			6'h09: c = 7'h38;
			6'h0A: c = 7'h39;
			6'h0B: c = 7'h30;
			6'h0C: c = 7'h2D;
			6'h0D: c = 7'h3D;
			6'h0E: c = KEY_BACK;
			6'h0F: c = KEY_TAB;
			6'h10: c = 7'h71;
			6'h11: c = 7'h77;
			6'h12: c = 7'h65;
			6'h13: c = 7'h72;
			6'h14: c = 7'h74;
			6'h15: c = 7'h79;
			6'h16: c = 7'h75;
			6'h17: c = 7'h69;
			6'h18: c = 7'h6F;
			6'h19: c = 7'h70;
			6'h1A: c = 7'h5B;
			6'h1B: c = 7'h5D;
			6'h1C: c = KEY_ENTER;
			6'h1E: c = 7'h61;
			6'h1F: c = 7'h73;
			6'h20: c = 7'h64;
			6'h21: c = 7'h66;
			6'h22: c = 7'h67;
			6'h23: c = 7'h68;
			6'h24: c = 7'h6A;
			6'h25: c = 7'h6B;
			6'h26: c = 7'h6C;
			6'h27: c = 7'h3B;
			6'h28: c = 7'h27;
			6'h29: c = 7'h60;
			6'h2B: c = 7'h5C;
			6'h2C: c = 7'h7A;
			6'h2D: c = 7'h78;
			6'h2E: c = 7'h63;
			6'h2F: c = 7'h76;
			6'h30: c = 7'h62;
			6'h31: c = 7'h6E;
			6'h32: c = 7'h6D;
			6'h33: c = 7'h2C;
			6'h34: c = 7'h2E;
			6'h35: c = 7'h2F;
			6'h37: c = 7'h2A;
			6'h39: c = 7'h20;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] digit_shifted(input logic [3:0] d);
		logic [6:0] c;
		unique case (d)
			4'd0: c = 7'h29;
			4'd1: c = 7'h21;
			4'd2: c = 7'h40;
			4'd3: c = 7'h23;
			4'd4: c = 7'h24;
			4'd5: c = 7'h25;
			4'd6: c = 7'h5E;
			4'd7: c = 7'h26;
			4'd8: c = 7'h2A;
			4'd9: c = 7'h28;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] apply_shift(input logic [6:0] c, input logic sh);
		logic [6:0] r;
		r = c;
		if (sh) begin
			priority if (c >= 7'h61 && c <= 7'h7A) r = c - 7'h20;
			else if (c >= 7'h30 && c <= 7'h39) r = digit_shifted(c[3:0]);
			else if (c == 7'h3B) r = 7'h3A;
			else if (c == 7'h27) r = 7'h22;
			else if (c == 7'h2D) r = 7'h5F;
			else if (c == 7'h3D) r = 7'h2B;
			else r = c;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/sc1a_decode.sv =====
// Prefix tracking, modifier state and character lookup for one byte.
// Depends on sc1a_pkg and scancode_set1_to_ascii_defines.svh.
`default_nettype none
`include "scancode_set1_to_ascii_defines.svh"
module sc1a_decode
	import sc1a_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] scan_byte,
	output sc1a_res_t       res
);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_WAIT1 = 2'd1;
	localparam logic [1:0] PH_WAIT2 = 2'd2;

	logic       ext_q, ext_n;
	logic [1:0] phase_q, phase_n;
	logic [7:0] first_q, first_n;
	logic       ctrl_q, ctrl_n;
	logic       alt_q, alt_n;
	logic       shift_q, shift_n;

	logic       brk;
	logic [7:0] b_s;
	logic [7:0] lo;
	logic       hi_zero;
	logic       use_code;
	logic       hit;

	always_comb begin
		brk = scan_byte[7] && ((phase_q != PH_IDLE) || (scan_byte != SC_PAUSE)) &&
			(ext_q || (scan_byte != SC_EXT));
		b_s = brk ? (scan_byte & ~SC_BREAK_BIT) : scan_byte;

		ext_n    = ext_q;
		phase_n  = phase_q;
		first_n  = first_q;
		ctrl_n   = ctrl_q;
		alt_n    = alt_q;
		shift_n  = shift_q;
		lo       = b_s;
		hi_zero  = 1'b1;
		use_code = 1'b0;
		hit      = 1'b0;

		priority if (ext_q) begin
			ext_n    = 1'b0;
			use_code = !((b_s == SC_LSHIFT) || (b_s == SC_RSHIFT));
		end else if (phase_q[1]) begin
			phase_n  = PH_IDLE;
			lo       = first_q;
			hi_zero  = (b_s == 8'h00);
			use_code = 1'b1;
		end else if (phase_q == PH_WAIT1) begin
			first_n = b_s;
			phase_n = PH_WAIT2;
		end else if (b_s == SC_EXT) begin
			ext_n = 1'b1;
		end else if (b_s == SC_PAUSE) begin
			phase_n = PH_WAIT1;
		end else begin
			use_code = 1'b1;
		end

		if (use_code && hi_zero) begin
			priority if (lo == SC_CTRL) ctrl_n = !brk;
			else if ((lo == SC_LSHIFT) || (lo == SC_RSHIFT)) shift_n = !brk;
			else if (lo == SC_ALT) alt_n = !brk;
			else hit = !brk && (lo < SC_ROM_SIZE);
		end

		res.hit   = hit;
		res.ch    = apply_shift(char_rom(lo[5:0]), shift_q);
		res.ctrl  = ctrl_q;
		res.alt   = alt_q;
		res.shift = shift_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q   <= 1'b0;
			phase_q <= PH_IDLE;
			first_q <= 8'h00;
			ctrl_q  <= 1'b0;
			alt_q   <= 1'b0;
			shift_q <= 1'b0;
		end else if (step) begin
			ext_q   <= ext_n;
			phase_q <= phase_n;
			first_q <= first_n;
			ctrl_q  <= ctrl_n;
			alt_q   <= alt_n;
			shift_q <= shift_n;
		end
	end

	`SC1A_NEVER(a_prefix_excl, ext_q && (phase_q != PH_IDLE))
	`SC1A_NEVER(a_phase_legal, phase_q == 2'd3)
	`SC1A_ASSERT(a_hit_keeps_mods, step && hit |=> $stable({ctrl_q, alt_q, shift_q}))

endmodule
`default_nettype wire

// ===== sv/scancode_set1_to_ascii.sv =====
// Top level: input stage register, byte decoder and result register.
// Depends on sc1a_pkg, sc1a_decode and scancode_set1_to_ascii_defines.svh.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | in_valid, in_ready, scan_byte[7:0]        | in
//   out     | out_valid, out_ready, ascii_char[6:0],    | out
//           | ctrl_held, alt_held, shift_held           |
//
// One byte per cycle sustained; a byte with a result passes the input stage
// and result registers. The input stage register holds one byte and the
// result register one result, so a new byte is taken while a result waits.
// A byte that gives a result holds in the input stage while the result
// register is full and not taken; bytes without a result never stall.
// Reset clears all prefix and modifier state.
`default_nettype none
`include "scancode_set1_to_ascii_defines.svh"
module scancode_set1_to_ascii
	import sc1a_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] scan_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [6:0]      ascii_char,
	output logic            ctrl_held,
	output logic            alt_held,
	output logic            shift_held
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic [6:0] ch_q;
	logic       ctrl_q, alt_q, shift_q;
	logic       advance;
	sc1a_res_t  res;

	sc1a_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.scan_byte (byte_s1),
		.res       (res)
	);

	assign advance  = valid_s1 && (!res.hit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= scan_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.hit) begin
			ch_q    <= res.ch;
			ctrl_q  <= res.ctrl;
			alt_q   <= res.alt;
			shift_q <= res.shift;
		end
	end

	assign out_valid  = out_valid_q;
	assign ascii_char = ch_q;
	assign ctrl_held  = ctrl_q;
	assign alt_held   = alt_q;
	assign shift_held = shift_q;

	`SC1A_NEVER(a_no_overwrite, out_valid_q && !out_ready && res.hit && advance)
	`SC1A_ASSERT(a_ready_when_empty, !valid_s1 |-> in_ready)
	`SC1A_ASSERT(a_held_byte_stable, valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))

endmodule
`default_nettype wire
